@@ rtl/rmq_pkg.sv @@
// Package for the rotation-matrix-to-quaternion block: payload types, widths, constants.
// Used by every file in rtl.
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int SQ_W = 32;
    localparam int ROOT_W = SQ_W / 2;
    localparam logic signed [18:0] ONE_FIX = 19'sd16384;
    localparam logic [15:0] PRE_LIM = 16'd32767;
    localparam logic [15:0] TINY_FIX = 16'd0;

    typedef struct packed {
        logic signed [15:0] row0_col0;
        logic signed [15:0] row0_col1;
        logic signed [15:0] row0_col2;
        logic signed [15:0] row1_col0;
        logic signed [15:0] row1_col1;
        logic signed [15:0] row1_col2;
        logic signed [15:0] row2_col0;
        logic signed [15:0] row2_col1;
        logic signed [15:0] row2_col2;
    } t_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               length_tiny;
    } t_out;

    typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} t_branch;

    typedef struct packed {
        t_branch            branch;
        logic [18:0]        rad;
        logic signed [17:0] a, b, c, d, e, f;
    } t_cls;

    // One step of a restoring square root: two radicand bits per step.
    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    function automatic t_sq sqrt_step(t_sq s, logic [1:0] bits);
        t_sq o;
        logic [SQ_W+1:0] r;
        logic [SQ_W+1:0] trial;
        r = {s.rem, bits};
        trial = {{(SQ_W-ROOT_W){1'b0}}, s.root, 2'b01};
        if (r >= trial) begin
            o.rem = SQ_W'(r - trial);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem = SQ_W'(r);
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Quotient bit step of restoring division.
    function automatic logic [34:0] div_step(logic [34:0] rem, logic [17:0] den,
                                             output logic qb);
        logic [34:0] t;
        t = rem - {17'd0, den};
        qb = !t[34];
        return qb ? t : rem;
    endfunction
endpackage

@@ rtl/rmq_front.sv @@
// Front part: picks the branch, forms radicand and numerators from the matrix, and registers them.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_cls o_cls
);
    logic r_valid;
    t_cls r_cls, n_cls;
    logic signed [18:0] m0, m4, m8, tr;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls = r_cls;

    always_comb begin
        m0 = 19'(i_data.row0_col0);
        m4 = 19'(i_data.row1_col1);
        m8 = 19'(i_data.row2_col2);
        tr = m0 + m4 + m8;
        n_cls.a = 18'(i_data.row2_col1) - 18'(i_data.row1_col2);
        n_cls.b = 18'(i_data.row0_col2) - 18'(i_data.row2_col0);
        n_cls.c = 18'(i_data.row1_col0) - 18'(i_data.row0_col1);
        n_cls.d = 18'(i_data.row0_col1) + 18'(i_data.row1_col0);
        n_cls.e = 18'(i_data.row0_col2) + 18'(i_data.row2_col0);
        n_cls.f = 18'(i_data.row1_col2) + 18'(i_data.row2_col1);
        if (tr > 0) begin
            n_cls.branch = BR_W;
            n_cls.rad = 19'(tr + ONE_FIX);
        end else if (m0 > m4 && m0 > m8) begin
            n_cls.branch = BR_X;
            n_cls.rad = 19'(ONE_FIX + m0 - m4 - m8);
        end else if (m4 > m8) begin
            n_cls.branch = BR_Y;
            n_cls.rad = 19'(ONE_FIX + m4 - m0 - m8);
        end else begin
            n_cls.branch = BR_Z;
            n_cls.rad = 19'(ONE_FIX + m8 - m0 - m4);
        end
        if ($signed(n_cls.rad) <= 0) n_cls.rad = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end
endmodule

@@ rtl/rmq_queue.sv @@
// Two-entry queue between front and back parts.
// Depends on rmq_pkg.
module rmq_queue import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_cls o_data
);
    t_cls r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

@@ rtl/rmq_back.sv @@
// Back part: pipelined square roots, divisions and normalization.
// Depends on rmq_pkg; every stage advances together when its slot moves.
module rmq_back import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_cls,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    // Stage plan: 8 root stages (2 steps each), 9 divide stages (2 bits each, 3 lanes),
    // clamp/square, sum, 8 root stages, 9 divide stages (4 lanes), output.
    localparam int NR = 8;
    localparam int ND = 9;
    localparam int NS = NR + ND + 2 + NR + ND + 1;

    logic [NS-1:0] r_v;
    logic adv;
    assign adv = !r_v[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-2:0], i_valid};
    end

    // ---- branch root ----
    typedef struct packed {
        t_sq sq; logic [SQ_W-1:0] src; t_branch br;
        logic signed [17:0] n0, n1, n2;
    } t_r1;
    t_r1 r_a [NR+1];
    always_comb begin
        r_a[0].sq = '0;
        r_a[0].src = {i_cls.rad[17:0], 14'd0};
        r_a[0].br = i_cls.branch;
        case (i_cls.branch)
            BR_W: begin r_a[0].n0 = i_cls.a; r_a[0].n1 = i_cls.b; r_a[0].n2 = i_cls.c; end
            BR_X: begin r_a[0].n0 = i_cls.a; r_a[0].n1 = i_cls.d; r_a[0].n2 = i_cls.e; end
            BR_Y: begin r_a[0].n0 = i_cls.b; r_a[0].n1 = i_cls.d; r_a[0].n2 = i_cls.f; end
            default: begin r_a[0].n0 = i_cls.c; r_a[0].n1 = i_cls.e; r_a[0].n2 = i_cls.f; end
        endcase
    end
    for (genvar g = 0; g < NR; g++) begin : g_r1
        t_r1 n_s;
        always_comb begin
            n_s = r_a[g];
            n_s.sq = sqrt_step(n_s.sq, n_s.src[SQ_W-1:SQ_W-2]);
            n_s.sq = sqrt_step(n_s.sq, n_s.src[SQ_W-3:SQ_W-4]);
            n_s.src = n_s.src << 4;
        end
        always_ff @(posedge i_clk) if (adv) r_a[g+1] <= n_s;
    end

    // ---- three divisions by s ----
    typedef struct packed {
        t_branch br; logic [ROOT_W-1:0] root; logic [17:0] den;
        logic [2:0] neg; logic [2:0] ovf; logic [2:0][34:0] rem; logic [2:0][33:0] num;
        logic [2:0][17:0] q;
    } t_d1;
    t_d1 r_d [ND+1];
    always_comb begin
        logic [17:0] mg [3];
        logic signed [17:0] nn [3];
        logic [30:0] dv [3];
        nn[0] = r_a[NR].n0; nn[1] = r_a[NR].n1; nn[2] = r_a[NR].n2;
        r_d[0].br = r_a[NR].br;
        r_d[0].root = r_a[NR].sq.root;
        r_d[0].den = {1'b0, r_a[NR].sq.root, 1'b0};
        for (int k = 0; k < 3; k++) begin
            r_d[0].neg[k] = nn[k][17];
            mg[k] = nn[k][17] ? 18'(-nn[k]) : 18'(nn[k]);
            dv[k] = {mg[k][16:0], 14'd0} + 31'(r_a[NR].sq.root);
            r_d[0].ovf[k] = 18'(dv[k][30:18]) >= r_d[0].den;
            r_d[0].rem[k] = 35'(dv[k][30:18]);
            r_d[0].num[k] = {dv[k][17:0], 16'd0};
            r_d[0].q[k] = '0;
        end
    end
    for (genvar g = 0; g < ND; g++) begin : g_d1
        t_d1 n_s;
        always_comb begin
            logic qb;
            n_s = r_d[g];
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 2; j++) begin
                    n_s.rem[k] = div_step({n_s.rem[k][33:0], n_s.num[k][33]}, n_s.den, qb);
                    n_s.num[k] = n_s.num[k] << 1;
                    n_s.q[k] = {n_s.q[k][16:0], qb};
                end
            end
        end
        always_ff @(posedge i_clk) if (adv) r_d[g+1] <= n_s;
    end

    // ---- assemble, clamp, square ----
    typedef struct packed { logic [3:0][15:0] q; logic [3:0][30:0] sq; } t_c;
    t_c r_c;
    logic [32:0] r_sum;
    logic [3:0][15:0] r_cq;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic [3:0][17:0] sv;
            logic [17:0] own;
            logic [17:0] qq [3];
            logic [17:0] mq;
            own = 18'((19'(r_d[ND].root) + 19'd1) >> 1);
            for (int k = 0; k < 3; k++) begin
                mq = (r_d[ND].ovf[k] || r_d[ND].q[k] > 18'(PRE_LIM)) ? 18'(PRE_LIM)
                                                                    : r_d[ND].q[k];
                qq[k] = r_d[ND].den == 0 ? 18'd0
                      : (r_d[ND].neg[k] ? 18'(-mq) : mq);
            end
            case (r_d[ND].br)
                BR_W: sv = {own, qq[0], qq[1], qq[2]};
                BR_X: sv = {qq[0], own, qq[1], qq[2]};
                BR_Y: sv = {qq[0], qq[1], own, qq[2]};
                default: sv = {qq[0], qq[1], qq[2], own};
            endcase
            for (int k = 0; k < 4; k++) begin
                logic signed [17:0] v;
                logic [15:0] mg;
                v = sv[k];
                if (v > $signed({2'b0, PRE_LIM})) v = {2'b0, PRE_LIM};
                if (v < -$signed({2'b0, PRE_LIM})) v = -$signed({2'b0, PRE_LIM});
                r_c.q[k] <= v[15:0];
                mg = v[17] ? 16'(-v) : 16'(v);
                r_c.sq[k] <= 31'({15'd0, mg} * {15'd0, mg});
            end
            r_sum <= 33'(r_c.sq[0]) + 33'(r_c.sq[1]) + 33'(r_c.sq[2]) + 33'(r_c.sq[3]);
            r_cq <= r_c.q;
        end
    end

    // ---- length root over the 33-bit sum ----
    typedef struct packed {
        logic [33:0] rem; logic [16:0] root; logic [33:0] src; logic [3:0][15:0] q;
    } t_r2;
    t_r2 r_b [NR+1];
    always_comb begin
        r_b[0].rem = '0; r_b[0].root = '0;
        r_b[0].src = {1'b0, r_sum}; r_b[0].q = r_cq;
    end
    for (genvar g = 0; g < NR; g++) begin : g_r2
        t_r2 n_s;
        always_comb begin
            logic [35:0] r, t;
            n_s = r_b[g];
            for (int j = 0; j < 2 + (g == NR-1 ? 1 : 0); j++) begin
                r = {n_s.rem, n_s.src[33:32]};
                t = {17'd0, n_s.root, 2'b01};
                if (r >= t) begin
                    n_s.rem = 34'(r - t); n_s.root = {n_s.root[15:0], 1'b1};
                end else begin
                    n_s.rem = 34'(r); n_s.root = {n_s.root[15:0], 1'b0};
                end
                n_s.src = n_s.src << 2;
            end
        end
        always_ff @(posedge i_clk) if (adv) r_b[g+1] <= n_s;
    end

    // ---- four divisions by n ----
    typedef struct packed {
        logic [17:0] den; logic [3:0] neg; logic [3:0][34:0] rem;
        logic [3:0][33:0] num; logic [3:0][17:0] q; logic [3:0][15:0] raw;
    } t_d2;
    t_d2 r_e [ND+1];
    always_comb begin
        logic [15:0] mg;
        logic [29:0] dv;
        r_e[0].den = {1'b0, r_b[NR].root};
        r_e[0].raw = r_b[NR].q;
        for (int k = 0; k < 4; k++) begin
            r_e[0].neg[k] = r_b[NR].q[k][15];
            mg = r_b[NR].q[k][15] ? 16'(-r_b[NR].q[k]) : r_b[NR].q[k];
            dv = {mg, 14'd0} + 30'(r_b[NR].root[16:1]);
            r_e[0].rem[k] = 35'(dv[29:18]);
            r_e[0].num[k] = {dv[17:0], 16'd0};
            r_e[0].q[k] = '0;
        end
    end
    for (genvar g = 0; g < ND; g++) begin : g_d2
        t_d2 n_s;
        always_comb begin
            logic qb;
            n_s = r_e[g];
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 2; j++) begin
                    n_s.rem[k] = div_step({n_s.rem[k][33:0], n_s.num[k][33]}, n_s.den, qb);
                    n_s.num[k] = n_s.num[k] << 1;
                    n_s.q[k] = {n_s.q[k][16:0], qb};
                end
            end
        end
        always_ff @(posedge i_clk) if (adv) r_e[g+1] <= n_s;
    end

    // ---- output ----
    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic tiny;
            logic [3:0][15:0] o;
            tiny = !(r_e[ND].den > {2'b0, TINY_FIX});
            for (int k = 0; k < 4; k++) begin
                logic signed [18:0] v;
                v = r_e[ND].neg[k] ? -$signed({1'b0, r_e[ND].q[k]})
                                   : $signed({1'b0, r_e[ND].q[k]});
                if (v > 19'sd32767) v = 19'sd32767;
                if (v < -19'sd32768) v = -19'sd32768;
                o[k] = tiny ? r_e[ND].raw[k] : v[15:0];
            end
            r_out <= {o[3], o[2], o[1], o[0], tiny};
        end
    end
    assign o_data = r_out;
endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Top level of the rotation-matrix-to-quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
//
// Input channel: i_valid/o_ready carry one 3x3 Q1.14 matrix per transaction.
// Output channel: o_valid/i_ready carry one Q1.14 quaternion plus a flag that
// is set when the length was zero and the components are left unnormalized.
// Throughput: one transaction per cycle in each direction while the receiver accepts.
// Path: the front classifier register, the queue, then the back pipeline (two square
// roots at two result bits per stage, three in the last length-root stage, and two
// restoring dividers at two quotient bits per stage set its depth).
// Reset clears every valid flag; payload is not reset.
// When the receiver stalls the back pipeline holds, the queue fills, and then
// o_ready drops; no transaction is lost or repeated.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    logic f_v, f_r, q_v, q_r;
    t_cls f_c, q_c;

    rmq_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid(f_v), .i_ready(f_r), .o_cls(f_c));
    rmq_queue u_queue (.i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_data(f_c),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_c));
    rmq_back u_back (.i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_cls(q_c),
        .o_valid, .i_ready, .o_data);
endmodule
